// ===== src/cap_pkg.sv =====
// package: shared types, register indexes and the divide-by-255 helper
package cap_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PROD_W    = 2 * BYTE_W;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned LANES     = 3;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONSTANT_ALPHA    = 3'd0,
        CFG_BLEND_OPERATION   = 3'd1,
        CFG_BLEND_FLAG_BITS   = 3'd2,
        CFG_ALPHA_FORMAT_BITS = 3'd3,
        CFG_SOURCE_IS_32BPP   = 3'd4
    } cfg_index_t;

    // blend operation code and the full-scale byte value
    localparam logic [BYTE_W-1:0] BLEND_OP_SRC_OVER = 8'd0;
    localparam logic [BYTE_W-1:0] BYTE_MAX          = 8'd255;

    // decoded configuration seen by the datapath
    typedef struct packed {
        logic [BYTE_W-1:0] constant_alpha;
        logic              per_pixel_alpha;
        logic              rejected;
    } cfg_t;

    // request leaving the source scaling half of the pipeline
    typedef struct packed {
        logic                         valid;
        logic                         rejected;
        logic [BYTE_W-1:0]            alpha;
        logic [LANES-1:0][BYTE_W-1:0] scaled;
        logic [LANES-1:0][BYTE_W-1:0] dst;
    } mid_t;

    // floor(x / 255) for x up to 255*255, by the add-and-shift identity
    function automatic logic [BYTE_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] sum;
        sum = {1'b0, x} + {{(BYTE_W + 1){1'b0}}, x[PROD_W-1:BYTE_W]} + 17'd1;
        return sum[PROD_W-1:BYTE_W];
    endfunction

endpackage

// ===== src/cap_cfg.sv =====
// configuration registers and unsupported-mode decode
module cap_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [cap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cap_pkg::BYTE_W-1:0]    cfg_data,
    output cap_pkg::cfg_t                 cfg
);

    logic [cap_pkg::BYTE_W-1:0] constant_alpha_reg;
    logic [cap_pkg::BYTE_W-1:0] blend_operation_reg;
    logic [cap_pkg::BYTE_W-1:0] blend_flag_bits_reg;
    logic [cap_pkg::BYTE_W-1:0] alpha_format_bits_reg;
    logic                       source_is_32bpp_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            constant_alpha_reg    <= cap_pkg::BYTE_MAX;
            blend_operation_reg   <= cap_pkg::BLEND_OP_SRC_OVER;
            blend_flag_bits_reg   <= '0;
            alpha_format_bits_reg <= '0;
            source_is_32bpp_reg   <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                cap_pkg::CFG_CONSTANT_ALPHA:    constant_alpha_reg    <= cfg_data;
                cap_pkg::CFG_BLEND_OPERATION:   blend_operation_reg   <= cfg_data;
                cap_pkg::CFG_BLEND_FLAG_BITS:   blend_flag_bits_reg   <= cfg_data;
                cap_pkg::CFG_ALPHA_FORMAT_BITS: alpha_format_bits_reg <= cfg_data;
                cap_pkg::CFG_SOURCE_IS_32BPP:   source_is_32bpp_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // unsupported modes: other op, any flag, unknown format bit, pixel alpha on non-32bpp
    always_comb
    begin
        cfg.constant_alpha  = constant_alpha_reg;
        cfg.per_pixel_alpha = alpha_format_bits_reg[0];
        cfg.rejected        = (blend_operation_reg != cap_pkg::BLEND_OP_SRC_OVER)
                            || (blend_flag_bits_reg != '0)
                            || (alpha_format_bits_reg[cap_pkg::BYTE_W-1:1] != '0)
                            || (alpha_format_bits_reg[0] && !source_is_32bpp_reg);
    end

endmodule

// ===== src/cap_front.sv =====
// stages 1-2: source scaling by constant alpha and effective alpha
module cap_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  cap_pkg::cfg_t              cfg,
    input  logic [cap_pkg::BYTE_W-1:0] src_red,
    input  logic [cap_pkg::BYTE_W-1:0] src_green,
    input  logic [cap_pkg::BYTE_W-1:0] src_blue,
    input  logic [cap_pkg::BYTE_W-1:0] src_alpha,
    input  logic [cap_pkg::BYTE_W-1:0] dst_byte0,
    input  logic [cap_pkg::BYTE_W-1:0] dst_byte1,
    input  logic [cap_pkg::BYTE_W-1:0] dst_byte2,
    output cap_pkg::mid_t              mid
);

    logic                                           valid1_reg;
    logic                                           rejected1_reg;
    logic                                           pp_alpha1_reg;
    logic [cap_pkg::BYTE_W-1:0]                     ca1_reg;
    logic [cap_pkg::LANES-1:0][cap_pkg::PROD_W-1:0] color_prod1_reg;
    logic [cap_pkg::PROD_W-1:0]                     alpha_prod1_reg;
    logic [cap_pkg::LANES-1:0][cap_pkg::BYTE_W-1:0] dst1_reg;
    logic [cap_pkg::PROD_W-1:0]                     ca_ext;
    cap_pkg::mid_t                                  mid_reg;
    cap_pkg::mid_t                                  mid_next;

    assign ca_ext = {{cap_pkg::BYTE_W{1'b0}}, cfg.constant_alpha};

    // stage 1 valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_valid;
        end
    end

    // stage 1: source bytes times constant alpha
    always_ff @(posedge clk)
    begin
        rejected1_reg      <= cfg.rejected;
        pp_alpha1_reg      <= cfg.per_pixel_alpha;
        ca1_reg            <= cfg.constant_alpha;
        color_prod1_reg[0] <= {{cap_pkg::BYTE_W{1'b0}}, src_red}   * ca_ext;
        color_prod1_reg[1] <= {{cap_pkg::BYTE_W{1'b0}}, src_green} * ca_ext;
        color_prod1_reg[2] <= {{cap_pkg::BYTE_W{1'b0}}, src_blue}  * ca_ext;
        alpha_prod1_reg    <= {{cap_pkg::BYTE_W{1'b0}}, src_alpha} * ca_ext;
        dst1_reg[0]        <= dst_byte0;
        dst1_reg[1]        <= dst_byte1;
        dst1_reg[2]        <= dst_byte2;
    end

    // stage 2: divide by 255 and pick the effective alpha
    always_comb
    begin
        mid_next          = mid_reg;
        mid_next.valid    = valid1_reg;
        mid_next.rejected = rejected1_reg;
        mid_next.alpha    = pp_alpha1_reg ? cap_pkg::div255(alpha_prod1_reg) : ca1_reg;
        for (int i = 0; i < cap_pkg::LANES; i++)
        begin
            mid_next.scaled[i] = cap_pkg::div255(color_prod1_reg[i]);
        end
        mid_next.dst      = dst1_reg;
    end

    // stage 2 register, valid bit cleared on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= '0;
        end
        else
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid = mid_reg;

endmodule

// ===== src/cap_back.sv =====
// stages 3-4: destination weighting, sum and output registers
module cap_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cap_pkg::mid_t              mid,
    output logic                       done,
    output logic [cap_pkg::BYTE_W-1:0] out_byte0,
    output logic [cap_pkg::BYTE_W-1:0] out_byte1,
    output logic [cap_pkg::BYTE_W-1:0] out_byte2,
    output logic                       rejected
);

    logic [cap_pkg::BYTE_W-1:0]                     inv_alpha;
    logic                                           valid3_reg;
    logic                                           rejected3_reg;
    logic [cap_pkg::LANES-1:0][cap_pkg::PROD_W-1:0] dst_prod3_reg;
    logic [cap_pkg::LANES-1:0][cap_pkg::BYTE_W-1:0] scaled3_reg;
    logic [cap_pkg::LANES-1:0][cap_pkg::BYTE_W-1:0] dst3_reg;
    logic                                           done_reg;
    logic                                           rejected_reg;
    logic [cap_pkg::LANES-1:0][cap_pkg::BYTE_W-1:0] out_reg;
    logic [cap_pkg::LANES-1:0][cap_pkg::BYTE_W-1:0] out_next;

    assign inv_alpha = cap_pkg::BYTE_MAX - mid.alpha;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid3_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            valid3_reg <= mid.valid;
            done_reg   <= valid3_reg;
        end
    end

    // stage 3: destination bytes times (255 - alpha)
    always_ff @(posedge clk)
    begin
        rejected3_reg <= mid.rejected;
        scaled3_reg   <= mid.scaled;
        dst3_reg      <= mid.dst;
        for (int i = 0; i < cap_pkg::LANES; i++)
        begin
            dst_prod3_reg[i] <= {{cap_pkg::BYTE_W{1'b0}}, mid.dst[i]}
                              * {{cap_pkg::BYTE_W{1'b0}}, inv_alpha};
        end
    end

    // stage 4: divide, add source part modulo 256, or pass destination through
    always_comb
    begin
        for (int i = 0; i < cap_pkg::LANES; i++)
        begin
            out_next[i] = rejected3_reg ? dst3_reg[i]
                                        : cap_pkg::div255(dst_prod3_reg[i]) + scaled3_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        rejected_reg <= rejected3_reg;
    end

    assign done      = done_reg;
    assign out_byte0 = out_reg[0];
    assign out_byte1 = out_reg[1];
    assign out_byte2 = out_reg[2];
    assign rejected  = rejected_reg;

endmodule

// ===== src/constant_alpha_pixel_blend.sv =====
// top level: constant-alpha source-over pixel blend pipeline
// a request accepted at an edge passes through stages 1-4, and its result is strobed by done
// throughput: one pixel per clock; busy is always low since all four stages advance every cycle
// the rate is set by the four-stage pipeline of 8x8 multiplies and divide-by-255 steps
// reset: rst_n clears the valid bits and loads the registers with their reset values
// the receiver cannot stall, so results leave on fixed cycles
module constant_alpha_pixel_blend (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cap_pkg::BYTE_W-1:0]    src_red,
    input  logic [cap_pkg::BYTE_W-1:0]    src_green,
    input  logic [cap_pkg::BYTE_W-1:0]    src_blue,
    input  logic [cap_pkg::BYTE_W-1:0]    src_alpha,
    input  logic [cap_pkg::BYTE_W-1:0]    dst_byte0,
    input  logic [cap_pkg::BYTE_W-1:0]    dst_byte1,
    input  logic [cap_pkg::BYTE_W-1:0]    dst_byte2,
    output logic                          done,
    output logic [cap_pkg::BYTE_W-1:0]    out_byte0,
    output logic [cap_pkg::BYTE_W-1:0]    out_byte1,
    output logic [cap_pkg::BYTE_W-1:0]    out_byte2,
    output logic                          rejected,
    input  logic                          cfg_wr_en,
    input  logic [cap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cap_pkg::BYTE_W-1:0]    cfg_data
);

    cap_pkg::cfg_t cfg;
    cap_pkg::mid_t mid;
    logic          accept;

    // pipeline never holds off a request
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    cap_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // source scaling half
    cap_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .cfg       (cfg),
        .src_red   (src_red),
        .src_green (src_green),
        .src_blue  (src_blue),
        .src_alpha (src_alpha),
        .dst_byte0 (dst_byte0),
        .dst_byte1 (dst_byte1),
        .dst_byte2 (dst_byte2),
        .mid       (mid)
    );

    // destination blend half
    cap_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid       (mid),
        .done      (done),
        .out_byte0 (out_byte0),
        .out_byte1 (out_byte1),
        .out_byte2 (out_byte2),
        .rejected  (rejected)
    );

`ifndef SYNTHESIS
    // every result comes from an earlier accepted request
    a_done_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 4))
        else $error("result without a matching request");

    // a rejected result carries the destination pixel of its request
    a_reject_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rejected) |-> (out_byte0 == $past(dst_byte0, 4))
                            && (out_byte1 == $past(dst_byte1, 4))
                            && (out_byte2 == $past(dst_byte2, 4)))
        else $error("rejected result does not match destination input");

    // an opaque source-over blend without pixel alpha returns the source colour
    a_opaque_copy: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(accept, 4) && $past(cfg.constant_alpha, 4) == cap_pkg::BYTE_MAX
            && !$past(cfg.per_pixel_alpha, 4) && !$past(cfg.rejected, 4))
        |-> (out_byte0 == $past(src_red, 4)) && (out_byte1 == $past(src_green, 4))
            && (out_byte2 == $past(src_blue, 4)))
        else $error("opaque blend does not copy the source");
`endif

endmodule

// ===== tb/constant_alpha_pixel_blend_tb.sv =====
// testbench for the constant-alpha pixel blend: directed table, random phases, self-checking
`timescale 1ns / 100ps

module constant_alpha_pixel_blend_tb;

    localparam int unsigned FULL_SCALE      = 255;
    localparam int unsigned PIPE_LATENCY    = 4;
    localparam int unsigned IDLE_PCT        = 29;
    localparam int unsigned NUM_PHASES      = 16;
    localparam int unsigned ITEMS_PER_PHASE = 50;
    localparam int unsigned REPORT_LIMIT    = 10;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned DIRECTED_ROWS   = 22;

    typedef struct packed {
        logic [cap_pkg::BYTE_W-1:0] const_alpha;
        logic [cap_pkg::BYTE_W-1:0] operation;
        logic [cap_pkg::BYTE_W-1:0] flags;
        logic [cap_pkg::BYTE_W-1:0] alpha_format;
        logic                       src_32bpp;
    } blend_cfg_t;

    typedef struct packed {
        logic [cap_pkg::BYTE_W-1:0] red;
        logic [cap_pkg::BYTE_W-1:0] green;
        logic [cap_pkg::BYTE_W-1:0] blue;
        logic [cap_pkg::BYTE_W-1:0] alpha;
        logic [cap_pkg::BYTE_W-1:0] dst0;
        logic [cap_pkg::BYTE_W-1:0] dst1;
        logic [cap_pkg::BYTE_W-1:0] dst2;
    } pixel_t;

    typedef struct packed {
        logic [cap_pkg::BYTE_W-1:0] byte0;
        logic [cap_pkg::BYTE_W-1:0] byte1;
        logic [cap_pkg::BYTE_W-1:0] byte2;
        logic                       rejected;
    } blend_result_t;

    typedef struct packed {
        blend_cfg_t    cfg;
        pixel_t        px;
        logic          typed;
        blend_result_t want;
    } directed_row_t;

    localparam blend_cfg_t RESET_CFG = '{8'd255, cap_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'h00, 1'b1};

    // directed rows: register setting, pixel, and a typed result where it is obvious
    localparam directed_row_t DIRECTED[DIRECTED_ROWS] = '{
        '{RESET_CFG, '{8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff}, 1'b1,
          '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{RESET_CFG, '{8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{8'hff, 8'hff, 8'hff, 1'b0}},
        '{RESET_CFG, '{8'ha5, 8'h5a, 8'h3c, 8'h00, 8'h12, 8'h34, 8'h56}, 1'b1,
          '{8'ha5, 8'h5a, 8'h3c, 1'b0}},
        '{'{8'd0, cap_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'h00, 1'b1},
          '{8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h80, 8'hff}, 1'b1,
          '{8'h00, 8'h80, 8'hff, 1'b0}},
        '{'{8'd0, cap_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'h00, 1'b1},
          '{8'h11, 8'h22, 8'h33, 8'h44, 8'hff, 8'hff, 8'hff}, 1'b1,
          '{8'hff, 8'hff, 8'hff, 1'b0}},
        '{'{8'd255, 8'h01, 8'h00, 8'h00, 1'b1},
          '{8'hff, 8'hff, 8'hff, 8'hff, 8'h01, 8'h02, 8'h03}, 1'b1,
          '{8'h01, 8'h02, 8'h03, 1'b1}},
        '{'{8'd255, 8'hff, 8'h00, 8'h00, 1'b1},
          '{8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 8'hff}, 1'b1,
          '{8'hff, 8'h00, 8'hff, 1'b1}},
        '{'{8'd255, cap_pkg::BLEND_OP_SRC_OVER, 8'h01, 8'h00, 1'b1},
          '{8'h77, 8'h88, 8'h99, 8'haa, 8'h10, 8'h20, 8'h30}, 1'b1,
          '{8'h10, 8'h20, 8'h30, 1'b1}},
        '{'{8'd255, cap_pkg::BLEND_OP_SRC_OVER, 8'h80, 8'h00, 1'b1},
          '{8'hff, 8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00}, 1'b1,
          '{8'h00, 8'hff, 8'h00, 1'b1}},
        '{'{8'd255, cap_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'h02, 1'b1},
          '{8'h01, 8'h02, 8'h03, 8'h04, 8'hfe, 8'hfd, 8'hfc}, 1'b1,
          '{8'hfe, 8'hfd, 8'hfc, 1'b1}},
        '{'{8'd255, cap_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'h81, 1'b1},
          '{8'h40, 8'h50, 8'h60, 8'h70, 8'h0f, 8'hf0, 8'h55}, 1'b1,
          '{8'h0f, 8'hf0, 8'h55, 1'b1}},
        '{'{8'd255, cap_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'h01, 1'b0},
          '{8'hff, 8'hff, 8'hff, 8'hff, 8'haa, 8'h55, 8'h00}, 1'b1,
          '{8'haa, 8'h55, 8'h00, 1'b1}},
        '{'{8'd255, cap_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'h00, 1'b0},
          '{8'h9c, 8'h3e, 8'hd1, 8'h00, 8'h42, 8'h24, 8'h81}, 1'b1,
          '{8'h9c, 8'h3e, 8'hd1, 1'b0}},
        '{'{8'd255, cap_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'h01, 1'b1},
          '{8'h80, 8'h01, 8'hff, 8'h00, 8'h80, 8'hff, 8'h01}, 1'b0, '0},
        '{'{8'd255, cap_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'h01, 1'b1},
          '{8'h80, 8'h01, 8'hff, 8'hff, 8'h80, 8'hff, 8'h01}, 1'b0, '0},
        '{'{8'd255, cap_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'h01, 1'b1},
          '{8'h80, 8'h01, 8'hff, 8'h80, 8'h80, 8'hff, 8'h01}, 1'b0, '0},
        '{'{8'd128, cap_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'h00, 1'b1},
          '{8'hc8, 8'h64, 8'h32, 8'h10, 8'hff, 8'h80, 8'h00}, 1'b0, '0},
        '{'{8'd1, cap_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'h00, 1'b1},
          '{8'hff, 8'hfe, 8'h01, 8'h99, 8'hff, 8'h01, 8'hfe}, 1'b0, '0},
        '{'{8'd254, cap_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'h00, 1'b1},
          '{8'hff, 8'h7f, 8'h00, 8'h33, 8'hff, 8'h7f, 8'h00}, 1'b0, '0},
        '{'{8'd200, cap_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'h01, 1'b1},
          '{8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
        '{'{8'd128, cap_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'h01, 1'b1},
          '{8'h3c, 8'hc3, 8'h96, 8'h7f, 8'h69, 8'h96, 8'hf0}, 1'b0, '0},
        '{'{8'd0, cap_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'h01, 1'b1},
          '{8'hff, 8'hff, 8'hff, 8'hff, 8'h12, 8'h34, 8'h56}, 1'b0, '0}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [cap_pkg::BYTE_W-1:0]    src_red;
    logic [cap_pkg::BYTE_W-1:0]    src_green;
    logic [cap_pkg::BYTE_W-1:0]    src_blue;
    logic [cap_pkg::BYTE_W-1:0]    src_alpha;
    logic [cap_pkg::BYTE_W-1:0]    dst_byte0;
    logic [cap_pkg::BYTE_W-1:0]    dst_byte1;
    logic [cap_pkg::BYTE_W-1:0]    dst_byte2;
    logic                          done;
    logic [cap_pkg::BYTE_W-1:0]    out_byte0;
    logic [cap_pkg::BYTE_W-1:0]    out_byte1;
    logic [cap_pkg::BYTE_W-1:0]    out_byte2;
    logic                          rejected;
    logic                          cfg_wr_en;
    logic [cap_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cap_pkg::BYTE_W-1:0]    cfg_data;

    // expected blended pixels, oldest first
    blend_result_t blended_q[$];
    blend_cfg_t    cfg_shadow = RESET_CFG;
    logic          typed_pending;
    blend_result_t typed_want;
    bit            idle_on;
    int unsigned   mismatch_count;
    int unsigned   accepted_count;
    int unsigned   rejected_count;
    int unsigned   setting_count;

    constant_alpha_pixel_blend u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .src_red   (src_red),
        .src_green (src_green),
        .src_blue  (src_blue),
        .src_alpha (src_alpha),
        .dst_byte0 (dst_byte0),
        .dst_byte1 (dst_byte1),
        .dst_byte2 (dst_byte2),
        .done      (done),
        .out_byte0 (out_byte0),
        .out_byte1 (out_byte1),
        .out_byte2 (out_byte2),
        .rejected  (rejected),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // one destination lane: faded destination plus scaled source, wrapping
    function automatic logic [cap_pkg::BYTE_W-1:0] mix_lane(int unsigned dst, int unsigned src,
                                                            int unsigned ca,
                                                            int unsigned eff_alpha);
        int unsigned sum;
        sum = (dst * (FULL_SCALE - eff_alpha)) / FULL_SCALE + (src * ca) / FULL_SCALE;
        return sum[cap_pkg::BYTE_W-1:0];
    endfunction

    // source-over blend of one pixel under a register setting
    function automatic blend_result_t blend_pixel(pixel_t px, blend_cfg_t c);
        blend_result_t r;
        int unsigned   ca;
        int unsigned   eff_alpha;
        ca = c.const_alpha;
        if (c.operation != cap_pkg::BLEND_OP_SRC_OVER || c.flags != '0
            || c.alpha_format[cap_pkg::BYTE_W-1:1] != '0
            || (c.alpha_format[0] && !c.src_32bpp))
        begin
            r = '{px.dst0, px.dst1, px.dst2, 1'b1};
            return r;
        end
        if (c.alpha_format[0])
            eff_alpha = (int'(px.alpha) * ca) / FULL_SCALE;
        else
            eff_alpha = ca;
        r.byte0    = mix_lane(px.dst0, px.red, ca, eff_alpha);
        r.byte1    = mix_lane(px.dst1, px.green, ca, eff_alpha);
        r.byte2    = mix_lane(px.dst2, px.blue, ca, eff_alpha);
        r.rejected = 1'b0;
        return r;
    endfunction

    function automatic logic [cap_pkg::BYTE_W-1:0] rand_byte();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return cap_pkg::BYTE_W'($urandom_range(0, FULL_SCALE));
    endfunction

    // mostly legal settings, about a quarter broken in one way
    function automatic blend_cfg_t pick_setting();
        blend_cfg_t c;
        case ($urandom_range(0, 5))
            0: c.const_alpha = '0;
            1: c.const_alpha = '1;
            default: c.const_alpha = cap_pkg::BYTE_W'($urandom_range(0, FULL_SCALE));
        endcase
        c.operation    = cap_pkg::BLEND_OP_SRC_OVER;
        c.flags        = '0;
        c.alpha_format = {7'd0, 1'($urandom_range(0, 1))};
        c.src_32bpp    = c.alpha_format[0] ? 1'b1 : 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 25)
        begin
            case ($urandom_range(0, 3))
                0: c.operation = cap_pkg::BYTE_W'($urandom_range(1, FULL_SCALE));
                1: c.flags = cap_pkg::BYTE_W'($urandom_range(1, FULL_SCALE));
                2: c.alpha_format = {7'($urandom_range(1, 127)), 1'($urandom_range(0, 1))};
                default:
                begin
                    c.alpha_format = 8'h01;
                    c.src_32bpp    = 1'b0;
                end
            endcase
        end
        return c;
    endfunction

    // register write, one cycle of enable
    task automatic write_reg(logic [cap_pkg::CFG_IDX_W-1:0] idx,
                             logic [cap_pkg::BYTE_W-1:0] data);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // stop sending and wait for every outstanding pixel to come back
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (blended_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // program a setting while idle; write_all forces every register
    task automatic apply_setting(blend_cfg_t c, bit write_all);
        drain();
        if (write_all || c.const_alpha != cfg_shadow.const_alpha)
            write_reg(cap_pkg::CFG_CONSTANT_ALPHA, c.const_alpha);
        if (write_all || c.operation != cfg_shadow.operation)
            write_reg(cap_pkg::CFG_BLEND_OPERATION, c.operation);
        if (write_all || c.flags != cfg_shadow.flags)
            write_reg(cap_pkg::CFG_BLEND_FLAG_BITS, c.flags);
        if (write_all || c.alpha_format != cfg_shadow.alpha_format)
            write_reg(cap_pkg::CFG_ALPHA_FORMAT_BITS, c.alpha_format);
        // upper data bits of the 1-bit register are junk on purpose
        if (write_all || c.src_32bpp != cfg_shadow.src_32bpp)
            write_reg(cap_pkg::CFG_SOURCE_IS_32BPP, {7'($urandom_range(0, 127)), c.src_32bpp});
        setting_count++;
    endtask

    // one request, with random idle cycles in front when idling is on
    task automatic send_pixel(pixel_t px, logic typed, blend_result_t want);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start         = 1'b1;
        src_red       = px.red;
        src_green     = px.green;
        src_blue      = px.blue;
        src_alpha     = px.alpha;
        dst_byte0     = px.dst0;
        dst_byte1     = px.dst1;
        dst_byte2     = px.dst2;
        typed_pending = typed;
        typed_want    = want;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic note_mismatch(string what, blend_result_t want, blend_result_t got);
        if (mismatch_count < REPORT_LIMIT)
            $display("mismatch %s: expected %02h %02h %02h rej %0b, got %02h %02h %02h rej %0b",
                     what, want.byte0, want.byte1, want.byte2, want.rejected,
                     got.byte0, got.byte1, got.byte2, got.rejected);
        mismatch_count++;
    endtask

    // monitor: check strobed results, predict accepted requests, track register writes
    always @(posedge clk)
    begin : monitor
        blend_result_t got;
        blend_result_t want;
        pixel_t        px;
        if (rst_n)
        begin
            got = '{out_byte0, out_byte1, out_byte2, rejected};
            if (done === 1'b1)
            begin
                if (blended_q.size() == 0)
                    note_mismatch("unexpected result", '0, got);
                else
                begin
                    want = blended_q.pop_front();
                    if (got.byte0 !== want.byte0 || got.byte1 !== want.byte1
                        || got.byte2 !== want.byte2 || got.rejected !== want.rejected)
                        note_mismatch("result", want, got);
                    if (want.rejected)
                        rejected_count++;
                end
            end
            else if (done !== 1'b0)
                note_mismatch("done unknown", '0, got);

            if (start && busy === 1'b0)
            begin
                px = '{src_red, src_green, src_blue, src_alpha, dst_byte0, dst_byte1, dst_byte2};
                blended_q.push_back(typed_pending ? typed_want : blend_pixel(px, cfg_shadow));
                accepted_count++;
            end

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    cap_pkg::CFG_CONSTANT_ALPHA:    cfg_shadow.const_alpha  = cfg_data;
                    cap_pkg::CFG_BLEND_OPERATION:   cfg_shadow.operation    = cfg_data;
                    cap_pkg::CFG_BLEND_FLAG_BITS:   cfg_shadow.flags        = cfg_data;
                    cap_pkg::CFG_ALPHA_FORMAT_BITS: cfg_shadow.alpha_format = cfg_data;
                    cap_pkg::CFG_SOURCE_IS_32BPP:   cfg_shadow.src_32bpp    = cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // run limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        pixel_t px;
        rst_n          = 1'b0;
        start          = 1'b0;
        src_red        = '0;
        src_green      = '0;
        src_blue       = '0;
        src_alpha      = '0;
        dst_byte0      = '0;
        dst_byte1      = '0;
        dst_byte2      = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        typed_pending  = 1'b0;
        typed_want     = '0;
        idle_on        = 1'b1;
        mismatch_count = 0;
        accepted_count = 0;
        rejected_count = 0;
        setting_count  = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table, registers changed only where a row asks
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIRECTED[i].cfg != cfg_shadow)
                apply_setting(DIRECTED[i].cfg, 1'b0);
            send_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].want);
        end

        // writes to unused indexes must leave the registers alone
        drain();
        for (int idx = int'(cap_pkg::CFG_SOURCE_IS_32BPP) + 1;
             idx < (1 << cap_pkg::CFG_IDX_W); idx++)
            write_reg(cap_pkg::CFG_IDX_W'(idx), rand_byte());

        // random phases, each under a fresh setting
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            apply_setting(pick_setting(), 1'b1);
            // two back-to-back phases with no idling at all
            idle_on = !(phase == 4 || phase == 5);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // one mid-phase pause until the pipeline is empty
                if (phase == 8 && n == ITEMS_PER_PHASE / 2)
                    drain();
                px = '{rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                       rand_byte(), rand_byte(), rand_byte()};
                send_pixel(px, 1'b0, '0);
            end
        end

        drain();
        if (blended_q.size() != 0)
            mismatch_count++;
        $display("covered %0d pixels over %0d register settings, %0d of them rejected",
                 accepted_count, setting_count + 1, rejected_count);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
src/cap_pkg.sv
src/cap_cfg.sv
src/cap_front.sv
src/cap_back.sv
src/constant_alpha_pixel_blend.sv
tb/constant_alpha_pixel_blend_tb.sv
